>>> hdl/ale_pkg.sv
package ale_pkg;

  // Operation codes carried by kind_i
  typedef enum logic [1:0] {
    KIND_APPEND = 2'd0,
    KIND_READ   = 2'd1,
    KIND_DELETE = 2'd2,
    KIND_FIND   = 2'd3
  } kind_e;

  // Result status codes
  localparam logic [1:0] STATUS_OK   = 2'd0;
  localparam logic [1:0] STATUS_MISS = 2'd1;  // out of range or not found
  localparam logic [1:0] STATUS_FULL = 2'd2;

  // Sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_SHIFT,
    S_FIND,
    S_DONE
  } state_e;

  localparam int unsigned CfgBits   = 9;
  localparam int unsigned ValueBits = 32;
  localparam int unsigned PosBits   = 8;
  localparam int unsigned UsedBits  = 9;

endpackage

>>> hdl/array_list_engine_top.sv
// Packed array list of signed values held in one simple dual-port RAM
// (one read and one write per cycle, registered read port) plus an entry
// count. One item at a time is taken; kind_i selects the operation:
// append stores item_value_i at the tail (status full when the count has
// reached the capacity), read returns the entry at position_i, delete
// removes position_i and moves every later entry down one place, find
// returns the lowest index holding item_value_i. Read or delete at or past
// the count, and a find with no match, give status 1. Every item produces
// exactly one result, and entries_used_o always shows the count after the
// operation. A delete moves one entry per cycle and a find compares one
// entry per cycle, both paced by the RAM port. A finished result sits in
// an output register, and the next item is taken while that result still
// waits on a stalled consumer. Writing the capacity register (cfg_we_i)
// empties the list; do so only while the block is idle. There is no
// clearing pass after reset.
module array_list_engine_top #(
  parameter int unsigned DEPTH      = 256,
  parameter int unsigned VALUE_BITS = 32
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // configuration
  input  logic                               cfg_we_i,
  input  logic [ale_pkg::CfgBits-1:0]        cfg_wdata_i,
  // input channel
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [1:0]                         kind_i,
  input  logic [ale_pkg::PosBits-1:0]        position_i,
  input  logic signed [ale_pkg::ValueBits-1:0] item_value_i,
  // output channel
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic signed [ale_pkg::ValueBits-1:0] read_value_o,
  output logic [ale_pkg::PosBits-1:0]        found_index_o,
  output logic [1:0]                         status_o,
  output logic [ale_pkg::UsedBits-1:0]       entries_used_o
);

  import ale_pkg::*;

  // count spans 0..DEPTH; capacity register is at least the port width
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam int unsigned CAP_W = (CNT_W > CfgBits) ? CNT_W : CfgBits;
  localparam int unsigned W     = CAP_W + 1;  // compare/arith width

  state_e state_q, state_d;

  logic [CNT_W-1:0]      count_q, count_d;
  logic [CAP_W-1:0]      cap_q, cap_d;
  logic [CNT_W-1:0]      idx_q, idx_d;
  logic [VALUE_BITS-1:0] val_q, val_d;

  // pending result, moved to the output register in S_DONE
  logic [ValueBits-1:0]  res_rd_q, res_rd_d;
  logic [PosBits-1:0]    res_idx_q, res_idx_d;
  logic [1:0]            res_st_q, res_st_d;

  logic                  out_valid_q, out_valid_d;
  logic [ValueBits-1:0]  out_rd_q, out_rd_d;
  logic [PosBits-1:0]    out_idx_q, out_idx_d;
  logic [1:0]            out_st_q, out_st_d;
  logic [UsedBits-1:0]   out_used_q, out_used_d;

  // RAM port
  logic                  mem_we;
  logic [AW-1:0]         mem_waddr;
  logic [VALUE_BITS-1:0] mem_wdata;
  logic [AW-1:0]         mem_raddr;
  logic [VALUE_BITS-1:0] mem_rdata;

  logic                  in_take;
  logic                  out_free;
  logic [W-1:0]          count_w;
  logic [W-1:0]          cap_lim;
  logic [W-1:0]          pos_w;
  logic [W-1:0]          idx_w;
  logic [VALUE_BITS-1:0] in_val;
  logic [63:0]           rd_wide;

  ale_ram #(
    .Depth   (DEPTH),
    .AddrBits(AW),
    .DataBits(VALUE_BITS)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .raddr_i(mem_raddr),
    .rdata_o(mem_rdata)
  );

  assign in_take  = in_valid_i && (state_q == S_IDLE);
  assign out_free = !out_valid_q || !out_stall_i;
  assign count_w  = W'(count_q);
  assign cap_lim  = (W'(cap_q) > W'(DEPTH)) ? W'(DEPTH) : W'(cap_q);
  assign pos_w    = W'(position_i);
  assign idx_w    = W'(idx_q);
  assign in_val   = VALUE_BITS'($unsigned(item_value_i));
  // sign-extend the stored word, then keep the low 32 bits
  assign rd_wide  = 64'($signed(mem_rdata));

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_take) begin
          state_d = S_DONE;
          case (kind_i)
            KIND_READ: begin
              if (pos_w < count_w) state_d = S_READ;
            end
            KIND_DELETE: begin
              if (pos_w + W'(1) < count_w) state_d = S_SHIFT;
            end
            KIND_FIND: begin
              if (count_w != '0) state_d = S_FIND;
            end
            default: ;
          endcase
        end
      end
      S_READ:  state_d = S_DONE;
      S_SHIFT: begin
        if (idx_w + W'(2) >= count_w) state_d = S_DONE;
      end
      S_FIND: begin
        if (mem_rdata == val_q || idx_w + W'(1) >= count_w) state_d = S_DONE;
      end
      S_DONE: begin
        if (out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // datapath and RAM control
  always_comb begin
    count_d     = count_q;
    cap_d       = cap_q;
    idx_d       = idx_q;
    val_d       = val_q;
    res_rd_d    = res_rd_q;
    res_idx_d   = res_idx_q;
    res_st_d    = res_st_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_rd_d    = out_rd_q;
    out_idx_d   = out_idx_q;
    out_st_d    = out_st_q;
    out_used_d  = out_used_q;
    mem_we      = 1'b0;
    mem_waddr   = AW'(count_q);
    mem_wdata   = in_val;
    mem_raddr   = AW'(position_i);
    in_stall_o  = (state_q != S_IDLE);

    unique case (state_q)
      S_IDLE: begin
        val_d = in_val;
        case (kind_i)
          KIND_DELETE: mem_raddr = AW'(pos_w + W'(1));
          KIND_FIND:   mem_raddr = '0;
          default: ;
        endcase
        if (in_take) begin
          res_rd_d  = '0;
          res_idx_d = '0;
          res_st_d  = STATUS_OK;
          idx_d     = '0;
          case (kind_i)
            KIND_APPEND: begin
              if (count_w >= cap_lim) begin
                res_st_d = STATUS_FULL;
              end else begin
                mem_we  = 1'b1;
                count_d = count_q + CNT_W'(1);
              end
            end
            KIND_READ: begin
              if (pos_w >= count_w) res_st_d = STATUS_MISS;
            end
            KIND_DELETE: begin
              if (pos_w >= count_w) begin
                res_st_d = STATUS_MISS;
              end else begin
                idx_d = CNT_W'(position_i);
                // deleting the tail entry needs no move
                if (pos_w + W'(1) >= count_w) count_d = count_q - CNT_W'(1);
              end
            end
            KIND_FIND: begin
              if (count_w == '0) res_st_d = STATUS_MISS;
            end
            default: ;
          endcase
        end
      end
      S_READ: begin
        res_rd_d = rd_wide[ValueBits-1:0];
      end
      S_SHIFT: begin
        // rdata holds entry idx+1; move it down, fetch idx+2
        mem_we    = 1'b1;
        mem_waddr = AW'(idx_q);
        mem_wdata = mem_rdata;
        mem_raddr = AW'(idx_w + W'(2));
        idx_d     = idx_q + CNT_W'(1);
        if (idx_w + W'(2) >= count_w) count_d = count_q - CNT_W'(1);
      end
      S_FIND: begin
        // rdata holds entry idx; fetch idx+1 ahead
        mem_raddr = AW'(idx_w + W'(1));
        if (mem_rdata == val_q) begin
          res_idx_d = PosBits'(idx_q);
        end else begin
          idx_d = idx_q + CNT_W'(1);
          if (idx_w + W'(1) >= count_w) res_st_d = STATUS_MISS;
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_rd_d    = res_rd_q;
          out_idx_d   = res_idx_q;
          out_st_d    = res_st_q;
          out_used_d  = UsedBits'(count_q);
        end
      end
      default: ;
    endcase

    if (cfg_we_i) begin
      cap_d   = CAP_W'(cfg_wdata_i);
      count_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      cap_q       <= CAP_W'(DEPTH);
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      cap_q       <= cap_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q      <= idx_d;
    val_q      <= val_d;
    res_rd_q   <= res_rd_d;
    res_idx_q  <= res_idx_d;
    res_st_q   <= res_st_d;
    out_rd_q   <= out_rd_d;
    out_idx_q  <= out_idx_d;
    out_st_q   <= out_st_d;
    out_used_q <= out_used_d;
  end

  assign out_valid_o    = out_valid_q;
  assign read_value_o   = $signed(out_rd_q);
  assign found_index_o  = out_idx_q;
  assign status_o       = out_st_q;
  assign entries_used_o = out_used_q;

  // count never passes the effective capacity
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_w <= cap_lim)
    else $error("count above capacity");

  // no RAM write during a read or a find, or while a finished item is pending
  a_no_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_READ || state_q == S_DONE || state_q == S_FIND) |-> !mem_we)
    else $error("unexpected RAM write");

  // a finished item lands in the output register with the current count
  a_result_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE && out_free) |=>
      (out_valid_q && out_used_q == UsedBits'($past(count_q))))
    else $error("result not loaded");

  // new items only while nothing is in flight
  a_busy_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SHIFT || state_q == S_FIND) |=> in_stall_o)
    else $error("input taken mid-operation");

endmodule

>>> hdl/ale_ram.sv
module ale_ram #(
  parameter int unsigned Depth    = 256,
  parameter int unsigned AddrBits = 8,
  parameter int unsigned DataBits = 32
) (
  input  logic                clk_i,
  input  logic                we_i,
  input  logic [AddrBits-1:0] waddr_i,
  input  logic [DataBits-1:0] wdata_i,
  input  logic [AddrBits-1:0] raddr_i,
  output logic [DataBits-1:0] rdata_o
);

  logic [DataBits-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule
